FILE: src/client_flow_table_counter_unit_assert.svh
// Assertion helpers for the flow table counter; clocked on clk_i, off during reset.
`ifndef CLIENT_FLOW_TABLE_COUNTER_UNIT_ASSERT_SVH
`define CLIENT_FLOW_TABLE_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CFT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/cft_pkg.sv
package cft_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PORT_W     = 16;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned PROTO_W    = 8;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLOT_OUT_W = 4;

  localparam logic [PROTO_W-1:0] UDP_PROTOCOL = 8'd17;

  typedef enum logic [STATUS_W-1:0] {
    ST_COUNTED = 3'd0,
    ST_IGNORED = 3'd1,
    ST_FULL    = 3'd2,
    ST_REMOVED = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [PORT_W-1:0]  port;
    logic [COUNT_W-1:0] count;
  } flow_entry_t;

endpackage

FILE: src/cft_req_if.sv
interface cft_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [cft_pkg::PROTO_W-1:0]  ip_protocol;
  logic [cft_pkg::PORT_W-1:0]   dest_port;
  logic [cft_pkg::ADDR_W-1:0]   source_addr;
  logic [cft_pkg::PORT_W-1:0]   source_port;

  modport source (output valid, req_type, ip_protocol, dest_port, source_addr, source_port,
                  input ready);
  modport sink (input valid, req_type, ip_protocol, dest_port, source_addr, source_port,
                output ready);
endinterface

FILE: src/cft_rsp_if.sv
interface cft_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [cft_pkg::STATUS_W-1:0]   status;
  logic [cft_pkg::SLOT_OUT_W-1:0] slot_index;
  logic [cft_pkg::COUNT_W-1:0]    message_count;

  modport source (output valid, status, slot_index, message_count, input ready);
  modport sink (input valid, status, slot_index, message_count, output ready);
endinterface

FILE: src/cft_ram.sv
module cft_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: src/client_flow_table_counter_unit.sv
// Channel   Dir  Port     Payload
// request   in   req_i    req_type, ip_protocol, dest_port, source_addr, source_port
// response  out  rsp_o    status, slot_index, message_count
// config    in   cfg_*    listen port (write only)
//
// Ignored packets skip the scan; others are resolved by a linear scan of the flow RAM up to
// occupancy, one read per cycle through its read port, and a removal adds a move step.
// Reset clears occupancy and the listen port; RAM contents stay undefined and are never read
// above occupancy. A result waits in the output register; the next request is taken
// meanwhile but its result is held until that register frees.
`include "client_flow_table_counter_unit_assert.svh"

module client_flow_table_counter_unit #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  cft_req_if.sink                     req_i,
  cft_rsp_if.source                   rsp_o,
  input  logic                        cfg_we_i,
  input  logic [cft_pkg::PORT_W-1:0]  cfg_wdata_i
);

  localparam int unsigned SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned OCC_W   = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned ENTRY_W = $bits(cft_pkg::flow_entry_t);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MOVE = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]                       state_q, state_d;
  logic [OCC_W-1:0]                 occ_q, occ_d;
  logic [OCC_W-1:0]                 scan_q, scan_d;
  logic                             cmp_vld_q, cmp_vld_d;
  logic [SLOT_W-1:0]                cmp_idx_q, cmp_idx_d;
  logic [SLOT_W-1:0]                hit_slot_q, hit_slot_d;
  logic [cft_pkg::PORT_W-1:0]       listen_port_q;
  logic                             close_q, close_d;
  logic [cft_pkg::ADDR_W-1:0]       key_addr_q, key_addr_d;
  logic [cft_pkg::PORT_W-1:0]       key_port_q, key_port_d;
  cft_pkg::status_e                 res_status_q, res_status_d;
  logic [cft_pkg::SLOT_OUT_W-1:0]   res_slot_q, res_slot_d;
  logic [cft_pkg::COUNT_W-1:0]      res_count_q, res_count_d;
  logic                             rsp_valid_q, rsp_valid_d;
  cft_pkg::status_e                 rsp_status_q, rsp_status_d;
  logic [cft_pkg::SLOT_OUT_W-1:0]   rsp_slot_q, rsp_slot_d;
  logic [cft_pkg::COUNT_W-1:0]      rsp_count_q, rsp_count_d;

  logic                             ram_we, ram_re;
  logic [SLOT_W-1:0]                ram_waddr, ram_raddr;
  cft_pkg::flow_entry_t             ram_wdata, ram_rdata;

  logic                             req_fire, rsp_load, hit;
  logic [OCC_W-1:0]                 occ_last;
  logic [cft_pkg::COUNT_W-1:0]      inc_count;

  cft_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_flow_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready         = (state_q == S_IDLE);
  assign req_fire            = req_i.valid && req_i.ready;
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.slot_index    = rsp_slot_q;
  assign rsp_o.message_count = rsp_count_q;

  // compare result of the read issued last cycle
  assign hit       = cmp_vld_q && (ram_rdata.addr == key_addr_q) && (ram_rdata.port == key_port_q);
  assign occ_last  = occ_q - OCC_W'(1);
  assign inc_count = (ram_rdata.count == '1) ? ram_rdata.count
                                             : ram_rdata.count + cft_pkg::COUNT_W'(1);
  assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    scan_d       = scan_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    hit_slot_d   = hit_slot_q;
    close_d      = close_q;
    key_addr_d   = key_addr_q;
    key_port_d   = key_port_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_count_d  = res_count_q;
    ram_we       = 1'b0;
    ram_waddr    = cmp_idx_q;
    ram_wdata    = '{addr: key_addr_q, port: key_port_q, count: inc_count};
    ram_re       = 1'b0;
    ram_raddr    = scan_q[SLOT_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          close_d     = req_i.req_type;
          key_addr_d  = req_i.source_addr;
          key_port_d  = req_i.source_port;
          scan_d      = '0;
          res_slot_d  = '0;
          res_count_d = '0;
          if ((req_i.ip_protocol != cft_pkg::UDP_PROTOCOL) ||
              (req_i.dest_port != listen_port_q)) begin
            res_status_d = cft_pkg::ST_IGNORED;
            state_d      = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (close_q) begin
            // fetch the last entry to move into the freed slot
            ram_re     = 1'b1;
            ram_raddr  = occ_last[SLOT_W-1:0];
            occ_d      = occ_last;
            hit_slot_d = cmp_idx_q;
            state_d    = S_MOVE;
          end else begin
            ram_we       = 1'b1;
            res_status_d = cft_pkg::ST_COUNTED;
            res_slot_d   = cft_pkg::SLOT_OUT_W'(cmp_idx_q);
            res_count_d  = inc_count;
            state_d      = S_RESP;
          end
        end else if (scan_q < occ_q) begin
          ram_re    = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = scan_q[SLOT_W-1:0];
          scan_d    = scan_q + OCC_W'(1);
        end else begin
          state_d = S_RESP;
          if (close_q) begin
            res_status_d = cft_pkg::ST_UNKNOWN;
          end else if (occ_q >= OCC_W'(TABLE_SLOTS)) begin
            res_status_d = cft_pkg::ST_FULL;
          end else begin
            // append new flow with its first message counted
            ram_we       = 1'b1;
            ram_waddr    = occ_q[SLOT_W-1:0];
            ram_wdata    = '{addr: key_addr_q, port: key_port_q,
                             count: cft_pkg::COUNT_W'(1)};
            occ_d        = occ_q + OCC_W'(1);
            res_status_d = cft_pkg::ST_COUNTED;
            res_slot_d   = cft_pkg::SLOT_OUT_W'(occ_q);
            res_count_d  = cft_pkg::COUNT_W'(1);
          end
        end
      end
      S_MOVE: begin
        ram_we       = 1'b1;
        ram_waddr    = hit_slot_q;
        ram_wdata    = ram_rdata;
        res_status_d = cft_pkg::ST_REMOVED;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_slot_d   = rsp_slot_q;
    rsp_count_d  = rsp_count_q;
    if (rsp_load) begin
      rsp_valid_d  = 1'b1;
      rsp_status_d = res_status_q;
      rsp_slot_d   = res_slot_q;
      rsp_count_d  = res_count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      occ_q         <= '0;
      scan_q        <= '0;
      cmp_vld_q     <= 1'b0;
      rsp_valid_q   <= 1'b0;
      listen_port_q <= '0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      scan_q      <= scan_d;
      cmp_vld_q   <= cmp_vld_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        listen_port_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q    <= cmp_idx_d;
    hit_slot_q   <= hit_slot_d;
    close_q      <= close_d;
    key_addr_q   <= key_addr_d;
    key_port_q   <= key_port_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_count_q  <= res_count_d;
    rsp_status_q <= rsp_status_d;
    rsp_slot_q   <= rsp_slot_d;
    rsp_count_q  <= rsp_count_d;
  end

  `CFT_ASSERT_IMPL(a_no_write_idle, ram_we, state_q != S_IDLE, "flow RAM written while idle")
  `CFT_ASSERT_NEXT(a_occ_idle_stable, state_q == S_IDLE, $stable(occ_q), "occupancy moved from idle")
  `CFT_ASSERT_IMPL(a_scan_below_occ, ram_re && (state_q == S_SCAN) && !hit, scan_q < occ_q,
                   "scan read past occupancy")
  `CFT_ASSERT_IMPL(a_rsp_from_resp, $rose(rsp_valid_q), $past(state_q) == S_RESP,
                   "response raised outside response state")
  `CFT_ASSERT_IMPL(a_counted_nonzero, rsp_valid_q && (rsp_status_q == cft_pkg::ST_COUNTED),
                   rsp_count_q != '0, "counted result with zero count")

endmodule
